[hw/rtl/c_subset_lexer_top_macros.svh]
// assertion macros shared by the lexer checker
// no dependencies; included by name where assertions are written
`ifndef C_SUBSET_LEXER_TOP_MACROS_SVH
`define C_SUBSET_LEXER_TOP_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define CSLX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");

// next-cycle implication, disabled while rst is high
`define CSLX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

[hw/rtl/cslx_pkg.sv]
// lexer package: token kinds, character codes, keyword table, token payload type
// no dependencies
package cslx_pkg;

   // token kinds
   localparam logic [2:0] KIND_NUMBER  = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_KEYWORD = 3'd2;
   localparam logic [2:0] KIND_PUNCT   = 3'd3;
   localparam logic [2:0] KIND_EOF     = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // keyword codes
   localparam logic [1:0] KW_RETURN = 2'd0;
   localparam logic [1:0] KW_IF     = 2'd1;
   localparam logic [1:0] KW_ELSE   = 2'd2;
   localparam int         KW_COUNT  = 3;

   localparam logic [7:0] CHR_NUL  = 8'h00;
   localparam logic [7:0] CHR_EQ   = 8'h3D;
   localparam logic [7:0] CHR_BANG = 8'h21;
   localparam logic [7:0] CHR_LT   = 8'h3C;
   localparam logic [7:0] CHR_GT   = 8'h3E;

   localparam int VALUE_WIDTH = 63;

   // fixed-width part of one result
   typedef struct packed {
      logic [2:0]             kind;
      logic [1:0]             keyword_code;
      logic [VALUE_WIDTH-1:0] value;
      logic [7:0]             first_char;
      logic [7:0]             second_char;
   } cslx_tok_type;

   // keyword length
   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         KW_RETURN: len = 3'd6;
         KW_IF:     len = 3'd2;
         KW_ELSE:   len = 3'd4;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   // keyword text, one character by index
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         KW_RETURN: begin
            case (i)
               3'd0:    ch = 8'h72; // r
               3'd1:    ch = 8'h65; // e
               3'd2:    ch = 8'h74; // t
               3'd3:    ch = 8'h75; // u
               3'd4:    ch = 8'h72; // r
               3'd5:    ch = 8'h6E; // n
               default: ch = 8'h00;
            endcase
         end
         KW_IF: begin
            case (i)
               3'd0:    ch = 8'h69; // i
               3'd1:    ch = 8'h66; // f
               default: ch = 8'h00;
            endcase
         end
         KW_ELSE: begin
            case (i)
               3'd0:    ch = 8'h65; // e
               3'd1:    ch = 8'h6C; // l
               3'd2:    ch = 8'h73; // s
               3'd3:    ch = 8'h65; // e
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[hw/rtl/cslx_front.sv]
// lexer front end: classifies each byte, keeps the token state, forms up to two results
// depends on cslx_pkg
module cslx_front #(
   parameter int POS_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 char_code,
   output logic                       push,
   output logic                       two,
   output cslx_pkg::cslx_tok_type     tok0,
   output cslx_pkg::cslx_tok_type     tok1,
   output logic [POS_WIDTH-1:0]       start0,
   output logic [POS_WIDTH-1:0]       len0,
   output logic [POS_WIDTH-1:0]       start1,
   output logic [POS_WIDTH-1:0]       len1
);

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_NUM   = 3'd1;
   localparam logic [2:0] MODE_IDENT = 3'd2;
   localparam logic [2:0] MODE_HELD  = 3'd3;
   localparam logic [2:0] MODE_DROP  = 3'd4;

   localparam int VW = cslx_pkg::VALUE_WIDTH;

   logic [2:0]           mode_ff, mode_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic [POS_WIDTH-1:0] len_ff, len_in;
   logic [VW-1:0]        value_ff, value_in;
   logic [7:0]           held_ff, held_in;
   logic [2:0]           alive_ff, alive_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;

   logic is_dig, is_alpha, is_space, is_punct, is_holder;
   logic [VW+3:0] value_x10;
   logic [VW+3:0] value_sum;
   logic [POS_WIDTH-1:0] len_inc;

   logic                   f_ok, n_ok;
   cslx_pkg::cslx_tok_type f_tok, n_tok;
   logic [POS_WIDTH-1:0]   f_start, f_len, n_start, n_len;
   logic                   kw_found;

   assign is_dig    = char_code inside {[8'h30:8'h39]};
   assign is_alpha  = char_code inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
   assign is_space  = char_code inside {8'h20, [8'h09:8'h0D]};
   assign is_punct  = char_code inside {[8'h21:8'h2F], [8'h3A:8'h40],
                                        [8'h5B:8'h60], [8'h7B:8'h7E]};
   assign is_holder = char_code inside {cslx_pkg::CHR_EQ, cslx_pkg::CHR_BANG,
                                        cslx_pkg::CHR_LT, cslx_pkg::CHR_GT};

   // value * 10 + digit, exact, saturates when it passes the value width
   assign value_x10 = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0};
   assign value_sum = value_x10 + (VW+4)'(char_code[3:0]);

   assign len_inc = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      value_in = value_ff;
      held_in  = held_ff;
      alive_in = alive_ff;
      pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
      f_ok     = 1'b0;
      n_ok     = 1'b0;
      f_tok    = '0;
      n_tok    = '0;
      f_start  = '0;
      f_len    = '0;
      n_start  = '0;
      n_len    = '0;
      kw_found = 1'b0;

      if (mode_ff == MODE_DROP) begin
         if (char_code == cslx_pkg::CHR_NUL) begin
            n_ok       = 1'b1;
            n_tok.kind = cslx_pkg::KIND_EOF;
            n_start    = pos_ff;
            mode_in    = MODE_IDLE;
            start_in   = '0;
            len_in     = '0;
            value_in   = '0;
            held_in    = '0;
            alive_in   = 3'b111;
            pos_in     = '0;
         end
      end else if (mode_ff == MODE_NUM && is_dig) begin
         value_in = (|value_sum[VW+3:VW]) ? '1 : value_sum[VW-1:0];
         len_in   = len_inc;
      end else if (mode_ff == MODE_IDENT && (is_alpha || is_dig)) begin
         for (int k = 0; k < cslx_pkg::KW_COUNT; k++) begin
            if (!(len_ff < POS_WIDTH'(cslx_pkg::kw_len(2'(k))) &&
                  cslx_pkg::kw_char(2'(k), len_ff[2:0]) == char_code))
               alive_in[k] = 1'b0;
         end
         len_in = len_inc;
      end else if (mode_ff == MODE_HELD && char_code == cslx_pkg::CHR_EQ) begin
         n_ok              = 1'b1;
         n_tok.kind        = cslx_pkg::KIND_PUNCT;
         n_tok.first_char  = held_ff;
         n_tok.second_char = char_code;
         n_start           = start_ff;
         n_len             = POS_WIDTH'(2);
         mode_in           = MODE_IDLE;
         held_in           = '0;
      end else begin
         // close the open token
         case (mode_ff)
            MODE_NUM: begin
               f_ok       = 1'b1;
               f_tok.kind = cslx_pkg::KIND_NUMBER;
               f_tok.value = value_ff;
               f_start    = start_ff;
               f_len      = len_ff;
            end
            MODE_IDENT: begin
               f_ok       = 1'b1;
               f_tok.kind = cslx_pkg::KIND_IDENT;
               f_start    = start_ff;
               f_len      = len_ff;
               for (int k = 0; k < cslx_pkg::KW_COUNT; k++) begin
                  if (!kw_found && alive_ff[k] &&
                      len_ff == POS_WIDTH'(cslx_pkg::kw_len(2'(k)))) begin
                     kw_found           = 1'b1;
                     f_tok.kind         = cslx_pkg::KIND_KEYWORD;
                     f_tok.keyword_code = 2'(k);
                  end
               end
            end
            MODE_HELD: begin
               f_ok             = 1'b1;
               f_tok.kind       = cslx_pkg::KIND_PUNCT;
               f_tok.first_char = held_ff;
               f_start          = start_ff;
               f_len            = POS_WIDTH'(1);
            end
            default: f_ok = 1'b0;
         endcase
         mode_in  = MODE_IDLE;
         len_in   = '0;
         value_in = '0;
         held_in  = '0;
         alive_in = 3'b111;

         // then start on the new byte
         if (char_code == cslx_pkg::CHR_NUL) begin
            n_ok       = 1'b1;
            n_tok.kind = cslx_pkg::KIND_EOF;
            n_start    = pos_ff;
            start_in   = '0;
            pos_in     = '0;
         end else if (is_space) begin
            mode_in = MODE_IDLE;
         end else if (is_dig) begin
            mode_in  = MODE_NUM;
            start_in = pos_ff;
            len_in   = POS_WIDTH'(1);
            value_in = VW'(char_code[3:0]);
         end else if (is_alpha) begin
            mode_in  = MODE_IDENT;
            start_in = pos_ff;
            len_in   = POS_WIDTH'(1);
            for (int k = 0; k < cslx_pkg::KW_COUNT; k++)
               alive_in[k] = (cslx_pkg::kw_char(2'(k), 3'd0) == char_code);
         end else if (is_holder) begin
            mode_in  = MODE_HELD;
            start_in = pos_ff;
            held_in  = char_code;
         end else if (is_punct) begin
            n_ok             = 1'b1;
            n_tok.kind       = cslx_pkg::KIND_PUNCT;
            n_tok.first_char = char_code;
            n_start          = pos_ff;
            n_len            = POS_WIDTH'(1);
         end else begin
            n_ok       = 1'b1;
            n_tok.kind = cslx_pkg::KIND_ERROR;
            n_start    = pos_ff;
            mode_in    = MODE_DROP;
         end
      end
   end

   // pack: flushed token first, new result second
   assign push   = accept && (f_ok || n_ok);
   assign two    = f_ok && n_ok;
   assign tok0   = f_ok ? f_tok : n_tok;
   assign start0 = f_ok ? f_start : n_start;
   assign len0   = f_ok ? f_len : n_len;
   assign tok1   = n_tok;
   assign start1 = n_start;
   assign len1   = n_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         value_ff <= '0;
         held_ff  <= '0;
         alive_ff <= 3'b111;
         pos_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         value_ff <= value_in;
         held_ff  <= held_in;
         alive_ff <= alive_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[hw/rtl/cslx_back.sv]
// lexer back end: queue of per-byte result pairs and the serializer that hands out one result
// depends on cslx_pkg
module cslx_back #(
   parameter int POS_WIDTH = 16,
   parameter int DEPTH     = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          two,
   input  cslx_pkg::cslx_tok_type        tok0,
   input  cslx_pkg::cslx_tok_type        tok1,
   input  logic [POS_WIDTH-1:0]          start0,
   input  logic [POS_WIDTH-1:0]          len0,
   input  logic [POS_WIDTH-1:0]          start1,
   input  logic [POS_WIDTH-1:0]          len1,
   output logic                          full,
   output logic                          empty,
   input  logic                          pop,
   output cslx_pkg::cslx_tok_type        out_tok,
   output logic [POS_WIDTH-1:0]          out_start,
   output logic [POS_WIDTH-1:0]          out_len,
   output logic                          out_last
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cslx_pkg::cslx_tok_type tok0_mem [DEPTH];
   cslx_pkg::cslx_tok_type tok1_mem [DEPTH];
   logic [POS_WIDTH-1:0]   start0_mem [DEPTH];
   logic [POS_WIDTH-1:0]   len0_mem [DEPTH];
   logic [POS_WIDTH-1:0]   start1_mem [DEPTH];
   logic [POS_WIDTH-1:0]   len1_mem [DEPTH];
   logic                   two_mem [DEPTH];

   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sub_ff, sub_in;
   logic             do_push, do_take, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_take = pop && !empty;
   // entry leaves once its last result is taken
   assign do_pop  = do_take && (sub_ff || !two_mem[rd_ff]);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      sub_in   = sub_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_take)
         sub_in = !do_pop;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!do_push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         sub_ff   <= 1'b0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         tok0_mem[wr_ff]   <= tok0;
         tok1_mem[wr_ff]   <= tok1;
         start0_mem[wr_ff] <= start0;
         len0_mem[wr_ff]   <= len0;
         start1_mem[wr_ff] <= start1;
         len1_mem[wr_ff]   <= len1;
         two_mem[wr_ff]    <= two;
      end
   end

   assign out_tok   = sub_ff ? tok1_mem[rd_ff] : tok0_mem[rd_ff];
   assign out_start = sub_ff ? start1_mem[rd_ff] : start0_mem[rd_ff];
   assign out_len   = sub_ff ? len1_mem[rd_ff] : len0_mem[rd_ff];
   assign out_last  = sub_ff || !two_mem[rd_ff];

endmodule

[hw/rtl/c_subset_lexer_top.sv]
// c subset lexer top level: byte queue port in, token queue port out
// depends on cslx_pkg, cslx_front, cslx_back
//
// usage
// - input: drive req_char_code with req_push; a byte is taken at a clock edge with
//   req_push high and req_full low. byte 0 ends a string.
// - output: while rsp_empty is low the oldest result sits on the rsp_ ports; it is
//   taken at a clock edge with rsp_pop high. rsp_last marks the final result of a byte.
// - a token is reported when the byte after it arrives, so one byte gives zero, one
//   or two results (a flushed token and a new punctuator, end of input or error).
// - latency: results of a byte show on the rsp_ ports the cycle after it is taken
//   when the queue is empty.
// - throughput: one byte per cycle while req_full is low, set by the token state update
//   (the x10 plus digit add for numbers); one result per cycle goes out while not empty.
// - stall: results wait in a QUEUE_DEPTH-entry queue of per-byte result pairs;
//   req_full rises when it fills and the byte stream holds until space frees.
// - reset: synchronous, clears the token state, the position count and the queue.
module c_subset_lexer_top #(
   parameter int POS_WIDTH   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_char_code,
   // token output
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_kind,
   output logic [1:0]           rsp_keyword_code,
   output logic [62:0]          rsp_value,
   output logic [POS_WIDTH-1:0] rsp_start_res,
   output logic [POS_WIDTH-1:0] rsp_length,
   output logic [7:0]           rsp_first_char,
   output logic [7:0]           rsp_second_char,
   output logic                 rsp_last
);

   // front to back transfer
   logic                   accept;
   logic                   fr_push;
   logic                   fr_two;
   cslx_pkg::cslx_tok_type fr_tok0, fr_tok1;
   logic [POS_WIDTH-1:0]   fr_start0, fr_len0, fr_start1, fr_len1;

   // back output
   cslx_pkg::cslx_tok_type bk_tok;

   // a byte is taken only while the queue has a free entry
   assign accept = req_push && !req_full;

   cslx_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .push      (fr_push),
      .two       (fr_two),
      .tok0      (fr_tok0),
      .tok1      (fr_tok1),
      .start0    (fr_start0),
      .len0      (fr_len0),
      .start1    (fr_start1),
      .len1      (fr_len1)
   );

   cslx_back #(
      .POS_WIDTH (POS_WIDTH),
      .DEPTH     (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_push),
      .two       (fr_two),
      .tok0      (fr_tok0),
      .tok1      (fr_tok1),
      .start0    (fr_start0),
      .len0      (fr_len0),
      .start1    (fr_start1),
      .len1      (fr_len1),
      .full      (req_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .out_tok   (bk_tok),
      .out_start (rsp_start_res),
      .out_len   (rsp_length),
      .out_last  (rsp_last)
   );

   // unpack the head result onto the ports
   assign rsp_kind         = bk_tok.kind;
   assign rsp_keyword_code = bk_tok.keyword_code;
   assign rsp_value        = bk_tok.value;
   assign rsp_first_char   = bk_tok.first_char;
   assign rsp_second_char  = bk_tok.second_char;

endmodule

[hw/rtl/cslx_checker.sv]
// port-level checks for the lexer top level, attached by bind
// depends on cslx_pkg and c_subset_lexer_top_macros.svh
`include "c_subset_lexer_top_macros.svh"

module cslx_checker #(
   parameter int POS_WIDTH = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [2:0]           rsp_kind,
   input logic [1:0]           rsp_keyword_code,
   input logic [62:0]          rsp_value,
   input logic [POS_WIDTH-1:0] rsp_length,
   input logic [7:0]           rsp_first_char,
   input logic [7:0]           rsp_second_char
);

   logic                   head_valid;
   logic                   head_waits;
   logic                   not_number;
   logic                   not_keyword;
   logic                   head_punct;
   logic                   punct_single;
   logic                   punct_pair;
   logic [POS_WIDTH+10:0]  head_word;

   assign head_valid   = !rsp_empty;
   assign head_waits   = head_valid && !rsp_pop;
   assign not_number   = head_valid && rsp_kind != cslx_pkg::KIND_NUMBER;
   assign not_keyword  = head_valid && rsp_kind != cslx_pkg::KIND_KEYWORD;
   assign head_punct   = head_valid && rsp_kind == cslx_pkg::KIND_PUNCT;
   assign punct_single = rsp_length == POS_WIDTH'(1) && rsp_second_char == 8'h00 &&
                         rsp_first_char != 8'h00;
   assign punct_pair   = rsp_length == POS_WIDTH'(2) &&
                         rsp_second_char == cslx_pkg::CHR_EQ;
   assign head_word    = {rsp_kind, rsp_first_char, rsp_length};

   // no result straight after reset
   `CSLX_ASSERT_NXT(a_empty_after_reset, clock, 1'b0, reset, rsp_empty)

   // only numbers carry a value
   `CSLX_ASSERT_IMP(a_value_only_number, clock, reset, not_number, rsp_value == '0)

   // only keywords carry a keyword code
   `CSLX_ASSERT_IMP(a_code_only_keyword, clock, reset, not_keyword, rsp_keyword_code == '0)

   // punctuator length agrees with its second byte
   `CSLX_ASSERT_IMP(a_punct_shape, clock, reset, head_punct, punct_single || punct_pair)

   // a waiting result keeps its kind, first byte and length while not popped
   `CSLX_ASSERT_NXT(a_head_holds, clock, reset, head_waits, head_valid && $stable(head_word))

endmodule

bind c_subset_lexer_top cslx_checker #(
   .POS_WIDTH (POS_WIDTH)
) u_cslx_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_kind         (rsp_kind),
   .rsp_keyword_code (rsp_keyword_code),
   .rsp_value        (rsp_value),
   .rsp_length       (rsp_length),
   .rsp_first_char   (rsp_first_char),
   .rsp_second_char  (rsp_second_char)
);
